[design/pidarm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID with adaptive range mapping: shared package
// Word types, configuration register set, register indexes and constants.
// ----------------------------------------------------------------------------
package pidarm_pkg;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] measured;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               in_dead_band;
  } out_word_t;

  typedef struct packed {
    logic        [15:0] step_time;
    logic signed [15:0] out_max;
    logic signed [15:0] out_min;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
  } cfg_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd5;

  localparam logic signed [15:0] DB_LOW       = 16'sd315;
  localparam logic signed [15:0] DB_HIGH      = 16'sd325;
  localparam logic signed [15:0] DB_VALUE     = 16'sd1519;
  localparam int                 OUT_OFFSET   = 550;
  localparam logic [10:0]        MARK_CEIL    = 11'd1900;
  localparam logic [10:0]        MARK_FLOOR   = 11'd1350;
  localparam logic [15:0]        ZERO_SPAN_DIV = 16'd300;
  // ceil(2^30 / 100): divide by 100 as a multiply and a 30-bit shift
  localparam logic signed [24:0] MAP_RECIP    = 25'sd10737419;
  localparam int                 PCT_HIGH     = 70;
  localparam int                 PCT_LOW      = 30;

  // Shared divider: unsigned, one quotient bit per cycle
  localparam int unsigned DIV_NW = 50;
  localparam int unsigned DIV_DW = 16;
  localparam int unsigned DIV_CW = 6;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

[design/pidarm_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID with adaptive range mapping: shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidarm_div import pidarm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] num_q, num_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q, num_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift the next numerator bit in, subtract where it fits
      rem_d = fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
      num_d = {num_q[DIV_NW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule
`default_nettype wire

[design/pidarm_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID with adaptive range mapping: sequencer and datapath
// One registered multiplier and the shared divider, stepped by a sequencer.
// ----------------------------------------------------------------------------
module pidarm_core import pidarm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      start_i,
  input  in_word_t  in_i,
  input  logic      res_ready_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output out_word_t res_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P    = 4'd1;
  localparam logic [3:0] S_I1   = 4'd2;
  localparam logic [3:0] S_I2   = 4'd3;
  localparam logic [3:0] S_I3   = 4'd4;
  localparam logic [3:0] S_D1   = 4'd5;
  localparam logic [3:0] S_D2   = 4'd6;
  localparam logic [3:0] S_DW   = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_MARK = 4'd9;
  localparam logic [3:0] S_PCT  = 4'd10;
  localparam logic [3:0] S_PCTW = 4'd11;
  localparam logic [3:0] S_SEL  = 4'd12;
  localparam logic [3:0] S_MAP  = 4'd13;
  localparam logic [3:0] S_MAPW = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]         state_q, state_d;
  logic signed [16:0] err_q, err_d;
  logic signed [16:0] prev_err_q, prev_err_d;
  logic signed [23:0] acc_q, acc_d;
  logic signed [49:0] prod_q, prod_d;
  logic signed [51:0] pacc_q, pacc_d;
  logic signed [35:0] sum_q, sum_d;
  logic signed [44:0] pct_q, pct_d;
  logic [10:0]        high_q, high_d;
  logic [10:0]        low_q, low_d;
  logic               neg_q, neg_d;
  logic signed [15:0] drive_q, drive_d;
  logic               db_q, db_d;

  logic signed [24:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [35:0] acc_sum, lim_hi, lim_lo;
  logic signed [36:0] diff;
  logic signed [43:0] num100;
  logic signed [11:0] span;
  logic signed [51:0] dq;
  logic signed [24:0] mapped;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  pidarm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign mul_p   = 50'(mul_a) * 50'(mul_b);
  assign acc_sum = 36'(acc_q) + 36'(prod_q);
  assign lim_hi  = 36'(cfg_i.out_max) <<< 8;
  assign lim_lo  = 36'(cfg_i.out_min) <<< 8;
  assign diff    = 37'(sum_q) - signed'({26'd0, low_q});
  assign num100  = (44'(diff) <<< 6) + (44'(diff) <<< 5) + (44'(diff) <<< 2);
  assign span    = signed'({1'b0, high_q}) - signed'({1'b0, low_q});
  assign dq      = signed'(52'(div_rsp.quo));
  // quotient of the map division sits in bits 46 down to 30 of the product
  assign mapped  = (neg_q ? -25'(prod_q[46:30]) : 25'(prod_q[46:30]))
                   + 25'(cfg_i.out_min);

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    prev_err_d = prev_err_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    pacc_d     = pacc_q;
    sum_d      = sum_q;
    pct_d      = pct_q;
    high_d     = high_q;
    low_d      = low_q;
    neg_d      = neg_q;
    drive_d    = drive_q;
    db_d       = db_q;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (in_i.measured > DB_LOW && in_i.measured < DB_HIGH) begin
            drive_d = DB_VALUE;
            db_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            err_d   = 17'(in_i.target) - 17'(in_i.measured);
            db_d    = 1'b0;
            state_d = S_P;
          end
        end
      end
      S_P: begin
        mul_a   = 25'(err_q);
        mul_b   = 25'(cfg_i.gain_p);
        prod_d  = mul_p;
        state_d = S_I1;
      end
      S_I1: begin
        pacc_d  = (52'(prod_q) <<< 8) + (52'(OUT_OFFSET) <<< 16);
        mul_a   = signed'({9'd0, cfg_i.step_time});
        mul_b   = 25'(err_q);
        prod_d  = mul_p;
        state_d = S_I2;
      end
      S_I2: begin
        // clamp against the upper limit first, then the lower one
        if (acc_sum > lim_hi) begin
          acc_d = 24'(lim_hi);
        end else if (acc_sum < lim_lo) begin
          acc_d = 24'(lim_lo);
        end else begin
          acc_d = 24'(acc_sum);
        end
        state_d = S_I3;
      end
      S_I3: begin
        mul_a   = 25'(cfg_i.gain_i);
        mul_b   = 25'(acc_q);
        prod_d  = mul_p;
        state_d = S_D1;
      end
      S_D1: begin
        pacc_d     = pacc_q + 52'(prod_q);
        mul_a      = 25'(err_q) - 25'(prev_err_q);
        mul_b      = 25'(cfg_i.gain_d);
        prod_d     = mul_p;
        prev_err_d = err_q;
        state_d    = S_D2;
      end
      S_D2: begin
        if (cfg_i.step_time == '0) begin
          state_d = S_SUM;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'(prod_q[49] ? -prod_q : prod_q) << 16;
          div_req.den   = cfg_i.step_time;
          neg_d         = prod_q[49];
          state_d       = S_DW;
        end
      end
      S_DW: begin
        if (div_rsp.done) begin
          pacc_d  = pacc_q + (neg_q ? -dq : dq);
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        // divide by 65536, rounding toward zero
        sum_d   = 36'(pacc_q >>> 16) + 36'(pacc_q[51] && (pacc_q[15:0] != '0));
        state_d = S_MARK;
      end
      S_MARK: begin
        if (sum_q > signed'({25'd0, high_q}) && sum_q < signed'({25'd0, MARK_CEIL})) begin
          high_d = 11'(sum_q);
        end
        if (sum_q < signed'({25'd0, low_q}) && sum_q > signed'({25'd0, MARK_FLOOR})) begin
          low_d = 11'(sum_q);
        end
        state_d = S_PCT;
      end
      S_PCT: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'(num100[43] ? -num100 : num100);
        if (span == '0) begin
          div_req.den = ZERO_SPAN_DIV;
        end else begin
          div_req.den = DIV_DW'(span[11] ? -span : span);
        end
        neg_d   = num100[43] ^ span[11];
        state_d = S_PCTW;
      end
      S_PCTW: begin
        if (div_rsp.done) begin
          pct_d   = neg_q ? -45'(div_rsp.quo) : 45'(div_rsp.quo);
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        if (pct_q > 45'(PCT_HIGH)) begin
          drive_d = cfg_i.out_max;
          state_d = S_DONE;
        end else if (pct_q < 45'(PCT_LOW)) begin
          drive_d = cfg_i.out_min;
          state_d = S_DONE;
        end else begin
          mul_a   = signed'({17'd0, pct_q[7:0]});
          mul_b   = 25'(cfg_i.out_max) - 25'(cfg_i.out_min);
          prod_d  = mul_p;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        // divide the magnitude by 100 through the reciprocal; exact below 2^23
        mul_a   = MAP_RECIP;
        mul_b   = 25'(prod_q[49] ? -prod_q : prod_q);
        prod_d  = mul_p;
        neg_d   = prod_q[49];
        state_d = S_MAPW;
      end
      S_MAPW: begin
        if (mapped > 25'sd32767) begin
          drive_d = 16'sh7fff;
        end else if (mapped < -25'sd32768) begin
          drive_d = 16'sh8000;
        end else begin
          drive_d = 16'(mapped);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      prev_err_q <= '0;
      acc_q      <= '0;
      high_q     <= MARK_FLOOR;
      low_q      <= MARK_CEIL;
    end else begin
      state_q    <= state_d;
      prev_err_q <= prev_err_d;
      acc_q      <= acc_d;
      high_q     <= high_d;
      low_q      <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    prod_q  <= prod_d;
    pacc_q  <= pacc_d;
    sum_q   <= sum_d;
    pct_q   <= pct_d;
    neg_q   <= neg_d;
    drive_q <= drive_d;
    db_q    <= db_d;
  end

  assign busy_o             = state_q != S_IDLE;
  assign res_valid_o        = state_q == S_DONE;
  assign res_o.drive        = drive_q;
  assign res_o.in_dead_band = db_q;

endmodule
`default_nettype wire

[design/pid_with_adaptive_range_mapping.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID with adaptive range mapping: top level
// Fixed-point PID step with clamped integral, tracked range and mapped drive.
// ----------------------------------------------------------------------------
// One word in, one word out. A measured value inside the dead band answers
// 1519 and leaves all state untouched. Any other word runs a PID step on one
// registered multiplier and one shared divider that yields a quotient bit per
// cycle; the step needs the percentage division and, unless the step time is
// zero, the derivative division, while the final scaling by 100 is a
// reciprocal multiply. Input stall stays high until the result is handed to
// the output register, which lets the next word start while a result waits.
// Configuration writes take effect at once; write only while idle.
// ----------------------------------------------------------------------------
module pid_with_adaptive_range_mapping import pidarm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_data_q;
  logic      core_busy, res_valid, res_ready;
  out_word_t res;

  // decode register writes; unknown indexes drop
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_TIME: cfg_d.step_time = cfg_data_i;
        REG_OUT_MAX:   cfg_d.out_max   = cfg_data_i;
        REG_OUT_MIN:   cfg_d.out_min   = cfg_data_i;
        REG_GAIN_P:    cfg_d.gain_p    = cfg_data_i;
        REG_GAIN_I:    cfg_d.gain_i    = cfg_data_i;
        REG_GAIN_D:    cfg_d.gain_d    = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  pidarm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (in_valid_i && !core_busy),
    .in_i        (in_data_i),
    .res_ready_i (res_ready),
    .busy_o      (core_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register: take a result when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time <= 16'd256;
      cfg_q.out_max   <= 16'sd1900;
      cfg_q.out_min   <= 16'sd1350;
      cfg_q.gain_p    <= 16'sd256;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign in_stall_o  = core_busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("core not busy after accepting a word");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result dropped while output register full");

  a_dead_band_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_dead_band |-> out_data_o.drive == DB_VALUE)
    else $error("dead band flag without dead band value");
`endif

endmodule
`default_nettype wire
